// ----- design/huffman_code_builder_macros.svh -----
// Assertion macros for the Huffman code builder.
// Depends on nothing; included by the top level.
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH
`ifndef SYNTH
`define HCB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HCB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HCB_ASSERT(label, clk, rst_n, prop, msg)
`define HCB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- design/hcb_pkg.sv -----
// Package for the Huffman code builder: payload structs, sizes, queue entry.
// Depends on nothing.
package hcb_pkg;
  localparam int unsigned MaxSymbolsDefault = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned SumW    = 20;
  localparam int unsigned CodeW   = 15;

  typedef struct packed {
    logic [15:0] weight;
    logic        last_symbol;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  symbol_index;
    logic [3:0]  code_length;
    logic [14:0] code_bits;
    logic        last_code;
  } out_item_t;

  typedef struct packed {
    logic        keep;
    logic        last;
    logic [15:0] weight;
  } queue_entry_t;
endpackage

// ----- design/hcb_front.sv -----
// Front end of the Huffman code builder: accepts weights, counts them, marks
// overflow, and queues classified requests. Depends on hcb_pkg.
module hcb_front #(
  parameter int unsigned MaxSymbols = hcb_pkg::MaxSymbolsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcb_pkg::in_item_t     in_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output hcb_pkg::queue_entry_t q_data_o,
  output logic                  q_valid_o,
  input  logic                  q_ready_i
);
  localparam int unsigned CntW = $clog2(MaxSymbols + 1);

  hcb_pkg::queue_entry_t buf_q [2];
  logic [1:0] fill_q;
  logic       wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic       blocked_q;
  logic       push, pop;

  // hold off after a last request until the back end takes it
  assign in_ready_o = (fill_q != 2'd2) && !blocked_q;
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = fill_q != 2'd0;
  assign q_data_o = buf_q[rd_q];
  assign pop = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q].weight <= in_data_i.weight;
      buf_q[wr_q].last   <= in_data_i.last_symbol;
      buf_q[wr_q].keep   <= cnt_q < CntW'(MaxSymbols);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0; blocked_q <= 1'b0;
    end else begin
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_q <= !wr_q;
        if (in_data_i.last_symbol) begin
          cnt_q <= '0;
          blocked_q <= 1'b1;
        end else if (cnt_q < CntW'(MaxSymbols)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (pop) begin
        rd_q <= !rd_q;
        if (q_data_o.last) blocked_q <= 1'b0;
      end
    end
  end
endmodule

// ----- design/hcb_back.sv -----
// Back end of the Huffman code builder: stores leaves, merges by scan,
// walks codes and drives the output register. Depends on hcb_pkg.
module hcb_back #(
  parameter int unsigned MaxSymbols = hcb_pkg::MaxSymbolsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcb_pkg::queue_entry_t q_data_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  output hcb_pkg::out_item_t    out_data_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  busy_o
);
  localparam int unsigned Nodes = 2 * MaxSymbols - 1;
  localparam int unsigned NW    = $clog2(Nodes + 1);
  localparam int unsigned SW    = $clog2(MaxSymbols + 1);
  localparam int unsigned IW    = (MaxSymbols > 2) ? $clog2(MaxSymbols - 1) : 1;
  localparam int unsigned SumW  = hcb_pkg::SumW;
  localparam int unsigned CodeW = hcb_pkg::CodeW;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StMerge = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [hcb_pkg::SumW-1:0] weight_q [Nodes];
  logic [NW-1:0]            parent_q [Nodes];
  logic                     has_par_q [Nodes];
  logic [NW-1:0]            left_q [MaxSymbols-1];

  logic [2:0]    st_q;
  logic [SW-1:0] n_q;
  logic [NW-1:0] i_q, k_q, l_q, r_q, c_q;
  logic          hl_q, hr_q;
  logic [SW-1:0] sym_q;
  logic [3:0]    len_q;
  logic [hcb_pkg::CodeW-1:0] code_q;
  logic          ov_q;
  hcb_pkg::out_item_t ob_q;

  logic [NW-1:0] nn;
  assign nn = NW'(n_q);
  assign q_ready_o = st_q == StLoad;
  assign busy_o = st_q != StLoad;
  assign out_valid_o = ov_q;
  assign out_data_o = ob_q;

  logic take;
  assign take = q_valid_i && q_ready_o;

  // load the output register when it is empty or being drained
  logic emit;
  assign emit = (st_q == StEmit) && (!ov_q || out_ready_i);

  logic kfree, kless_l, kless_r;
  assign kfree   = !has_par_q[k_q];
  assign kless_l = weight_q[k_q] < weight_q[l_q];
  assign kless_r = weight_q[k_q] < weight_q[r_q];

  logic cup;
  assign cup = has_par_q[c_q] && (len_q != 4'hF);

  always_ff @(posedge clk_i) begin
    if (take && q_data_i.keep)
      weight_q[NW'(n_q)] <= SumW'(q_data_i.weight);
    if (st_q == StMerge) begin
      weight_q[i_q] <= weight_q[l_q] + weight_q[r_q];
      left_q[IW'(i_q - nn)] <= l_q;
      parent_q[l_q] <= i_q;
      parent_q[r_q] <= i_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; n_q <= '0; ov_q <= 1'b0; ob_q <= '0;
      i_q <= '0; k_q <= '0; l_q <= '0; r_q <= '0; c_q <= '0;
      hl_q <= 1'b0; hr_q <= 1'b0; sym_q <= '0; len_q <= '0; code_q <= '0;
      for (int j = 0; j < Nodes; j++) has_par_q[j] <= 1'b0;
    end else begin
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (st_q)
        StLoad: begin
          if (take) begin
            if (q_data_i.last) begin
              if (q_data_i.keep) n_q <= n_q + 1'b1;
              i_q <= NW'(n_q) + NW'(q_data_i.keep);
              k_q <= '0; hl_q <= 1'b0; hr_q <= 1'b0;
              st_q <= StScan;
              // free the new leaf and every internal node of this set
              for (int j = 0; j < Nodes; j++)
                if (j >= int'(n_q)) has_par_q[j] <= 1'b0;
            end else if (q_data_i.keep) begin
              has_par_q[NW'(n_q)] <= 1'b0;
              n_q <= n_q + 1'b1;
            end
          end
        end
        StScan: begin
          if (i_q >= NW'(2 * n_q - 1)) begin
            sym_q <= '0; c_q <= '0; len_q <= '0; code_q <= '0;
            st_q <= StWalk;
          end else if (k_q == i_q) begin
            st_q <= StMerge;
          end else begin
            if (kfree) begin
              if (!hl_q || kless_l) begin
                r_q <= l_q; hr_q <= hl_q; l_q <= k_q; hl_q <= 1'b1;
              end else if (!hr_q || kless_r) begin
                r_q <= k_q; hr_q <= 1'b1;
              end
            end
            k_q <= k_q + 1'b1;
          end
        end
        StMerge: begin
          has_par_q[l_q] <= 1'b1;
          has_par_q[r_q] <= 1'b1;
          i_q <= i_q + 1'b1;
          k_q <= '0; hl_q <= 1'b0; hr_q <= 1'b0;
          st_q <= StScan;
        end
        StWalk: begin
          if (cup) begin
            code_q <= code_q |
              (CodeW'(left_q[IW'(parent_q[c_q] - nn)] != c_q) << len_q);
            len_q <= len_q + 1'b1;
            c_q <= parent_q[c_q];
          end else begin
            st_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit) begin
            ob_q.symbol_index <= 4'(sym_q);
            ob_q.code_length  <= len_q;
            ob_q.code_bits    <= code_q;
            ob_q.last_code    <= sym_q == n_q - 1'b1;
            if (sym_q == n_q - 1'b1) begin
              n_q <= '0;
              st_q <= StLoad;
            end else begin
              sym_q <= sym_q + 1'b1;
              c_q <= NW'(sym_q + 1'b1);
              len_q <= '0; code_q <= '0;
              st_q <= StWalk;
            end
          end
        end
        default: st_q <= StLoad;
      endcase
    end
  end
endmodule

// ----- design/huffman_code_builder.sv -----
// Top level of the Huffman code builder: front end, queue and back end.
// Depends on hcb_pkg, hcb_front, hcb_back and the assertion macro header.
//
//  channel | direction | payload              | handshake
//  in      | input     | hcb_pkg::in_item_t   | in_valid_i / in_ready_o
//  out     | output    | hcb_pkg::out_item_t  | out_valid_o / out_ready_i
//
// A weight is registered in the queue and then stored by the back end. A set
// of n symbols is then built one merge at a time: for each new node i a scan
// steps through the nodes below i to find the two lightest free ones, and the
// merge step writes node i; then each code is walked up the tree and emitted.
// Reset empties the queue and returns the back end to loading.
// Input stalls from a last request until the back end takes it; two more
// requests then queue and the input stalls until the last code is emitted.
// A held output register holds the back end in its emit step.
`include "huffman_code_builder_macros.svh"
module huffman_code_builder #(
  parameter int unsigned MaxSymbols = hcb_pkg::MaxSymbolsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcb_pkg::in_item_t  in_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output hcb_pkg::out_item_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  hcb_pkg::queue_entry_t q_data;
  logic q_valid, q_ready, busy;

  // classify and buffer requests
  hcb_front #(.MaxSymbols(MaxSymbols)) u_front (
    .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_ready_o,
    .q_data_o(q_data), .q_valid_o(q_valid), .q_ready_i(q_ready)
  );

  // build the tree and emit codes
  hcb_back #(.MaxSymbols(MaxSymbols)) u_back (
    .clk_i, .rst_ni, .q_data_i(q_data), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .out_data_o, .out_valid_o, .out_ready_i, .busy_o(busy)
  );

  `HCB_ASSERT(a_no_take_busy, clk_i, rst_ni, busy |-> !q_ready, "queue drained while building")
  `HCB_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "code lost")
  `HCB_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o, "output valid after reset")
endmodule

// ----- verif/tb_huffman_code_builder.sv -----
// Self-checking testbench for huffman_code_builder: loads sets of symbol weights
// and checks every emitted code against a predictor. Depends on hcb_pkg and the RTL.
module tb_huffman_code_builder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSym   = 16;
  localparam int unsigned NodeMax  = 2 * MaxSym - 1;
  localparam logic [5:0]  NoParent = 6'h3F;
  localparam int unsigned CycleLimit = 2000000;

  // Scoreboard: keeps its own copy of the leaf weights and predicts the codes
  // of a whole set when the closing request arrives.
  class code_scoreboard;
    logic [19:0]          leaf_wt[MaxSym];
    int unsigned          n_held;
    hcb_pkg::out_item_t   pending_codes[$];
    int unsigned          errors;

    function new();
      n_held = 0;
      errors = 0;
    endfunction

    function void build_codes();
      logic [19:0] wt[NodeMax];
      logic [5:0]  par[NodeMax];
      int unsigned lchild[MaxSym];
      int unsigned l, r, c, f, len;
      bit have_l, have_r, bitv;
      logic [14:0] code;
      hcb_pkg::out_item_t res;
      for (int i = 0; i < NodeMax; i++) begin
        par[i] = NoParent;
        wt[i] = (i < MaxSym) ? leaf_wt[i] : '0;
      end
      // merge the two lightest free nodes, lower index first on a tie
      for (int i = n_held; i < 2 * n_held - 1; i++) begin
        have_l = 0; have_r = 0; l = 0; r = 0;
        for (int k = 0; k < i; k++) begin
          if (par[k] != NoParent) continue;
          if (!have_l || wt[k] < wt[l]) begin
            r = l; have_r = have_l; l = k; have_l = 1;
          end else if (!have_r || wt[k] < wt[r]) begin
            r = k; have_r = 1;
          end
        end
        wt[i] = wt[l] + wt[r];
        lchild[i - n_held] = l;
        par[l] = 6'(i);
        par[r] = 6'(i);
      end
      // walk each leaf up to the root; a left branch gives a 0
      for (int i = 0; i < n_held; i++) begin
        c = i; f = par[i]; len = 0; code = '0;
        while (f != NoParent && f >= n_held && f < 2 * n_held - 1) begin
          bitv = (lchild[f - n_held] == c) ? 1'b0 : 1'b1;
          code = code | (15'(bitv) << len);
          len++;
          c = f;
          f = par[f];
        end
        res.symbol_index = 4'(i);
        res.code_length  = 4'(len);
        res.code_bits    = code;
        res.last_code    = (i == n_held - 1);
        pending_codes.push_back(res);
      end
    endfunction

    function void note_request(hcb_pkg::in_item_t req);
      if (n_held < MaxSym) begin
        leaf_wt[n_held] = {4'b0, req.weight};
        n_held++;
      end
      if (req.last_symbol) begin
        build_codes();
        n_held = 0;
      end
    endfunction

    function void check_code(hcb_pkg::out_item_t got);
      hcb_pkg::out_item_t want;
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code %h", $time, got);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      if (got.symbol_index !== want.symbol_index || got.code_length !== want.code_length ||
          got.code_bits !== want.code_bits || got.last_code !== want.last_code) begin
        $display("%0t: code mismatch expected idx=%0d len=%0d bits=%h last=%0d",
                 $time, want.symbol_index, want.code_length, want.code_bits,
                 want.last_code);
        $display("%0t:               actual idx=%0d len=%0d bits=%h last=%0d",
                 $time, got.symbol_index, got.code_length, got.code_bits,
                 got.last_code);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  hcb_pkg::in_item_t  in_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  hcb_pkg::out_item_t out_data_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;

  code_scoreboard sb = new();
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 84;
  bit          hold_off = 0;
  int unsigned cycles = 0;

  always #4 clk_i = ~clk_i;

  huffman_code_builder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_data_i(in_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_data_o(out_data_o), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i)
  );

  // Note accepted requests and check accepted codes on the same edge the DUT sees.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_code(out_data_o);
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one request and hold it until accepted; idle first at random.
  // Valid stays high after acceptance until the next request or stop_input.
  task automatic send_request(input logic [15:0] wt, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= '{weight: wt, last_symbol: last};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid once the sender has nothing more to offer.
  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_set(input int unsigned count, input int unsigned mode);
    logic [15:0] wt;
    for (int i = 0; i < count; i++) begin
      case (mode)
        0: wt = 16'($urandom);
        1: wt = 16'($urandom_range(7));
        default: wt = ($urandom_range(1)) ? 16'hFFFF : 16'($urandom);
      endcase
      send_request(wt, i == count - 1);
    end
  endtask

  task automatic drain();
    while (sb.pending_codes.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_sets(input int unsigned budget);
    int unsigned sent = 0, cnt;
    while (sent < budget) begin
      // mostly small sets, a few overfull ones
      cnt = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
      send_set(cnt, $urandom_range(2));
      sent += cnt;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single symbol, zero and full-scale weights, ties, two symbols.
    send_request(16'h0000, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFF, 1'b1);
    send_request(16'h0005, 1'b0);
    send_request(16'h0005, 1'b0);
    send_request(16'h0005, 1'b0);
    send_request(16'h0005, 1'b1);
    // Overfull set: the extra weights are dropped, the last still closes it.
    for (int i = 0; i < 18; i++) send_request(16'(1 << (i % 16)), i == 17);
    stop_input();
    drain();

    // Sender pauses until every code is back, then a long receiver hold-off
    // while the sender keeps offering so the block backs up.
    hold_off = 1;
    fork
      begin
        send_set(6, 0);
        send_set(5, 0);
        stop_input();
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
    join

    random_sets(55);
    send_idle_pct = 84; recv_idle_pct = 37;
    random_sets(55);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_sets(55);
    stop_input();

    drain();
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_codes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/hcb_pkg.sv
design/hcb_front.sv
design/hcb_back.sv
design/huffman_code_builder.sv
verif/tb_huffman_code_builder.sv
